@@ rtl/wmm_pkg.sv @@
package wmm_pkg;

    localparam int MAX_MASK_DEF = 64;
    localparam int CHAR_W       = 16;

    localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_QUERY = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 16'h007A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 16'h0020;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              wr;
        logic              step;
        logic              start;
        logic              clear;
        logic [CHAR_W-1:0] chr;
    } t_cell_ctl;

    // ASCII a-z to upper case, everything else untouched
    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

@@ rtl/wmm_in_if.sv @@
interface wmm_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [wmm_pkg::CHAR_W-1:0] character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

@@ rtl/wmm_out_if.sv @@
interface wmm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic mask_invalid;

    modport source (output valid, output matched, output mask_invalid, input ready);
    modport sink   (input valid, input matched, input mask_invalid, output ready);
endinterface

@@ rtl/wmm_cell.sv @@
module wmm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wmm_pkg::t_cell_ctl  i_ctl,
    input  logic [CNT_W-1:0]    i_len,
    input  logic                i_seed,
    input  logic                i_fwd,
    input  logic                i_lstar_t,
    output logic                o_fwd,
    output logic                o_star_t,
    output logic                o_star_v,
    output logic                o_act
);

    logic [wmm_pkg::CHAR_W-1:0] r_char;
    logic                       r_act;
    logic                       n_act;
    logic                       w_valid;
    logic                       w_star;
    logic                       w_query;
    logic                       w_act;
    logic                       w_t;

    assign w_valid = i_len > CNT_W'(IDX);
    assign w_star  = r_char == wmm_pkg::CH_STAR;
    assign w_query = r_char == wmm_pkg::CH_QUERY;

    // fresh name: only the seed positions are live
    assign w_act = i_ctl.start ? i_seed : r_act;

    // consume one char and move right
    assign o_fwd = w_act & w_valid & ~w_star & (w_query | (r_char == i_ctl.chr));
    // star holds itself; left neighbor may hand in a step
    assign w_t      = (w_act & w_valid & w_star) | i_fwd;
    // empty run through a star; stars are stored without repeats
    assign o_star_t = w_valid & w_star & w_t;
    assign o_star_v = w_valid & w_star;
    assign o_act    = w_act;

    always_comb begin
        n_act = r_act;
        if (i_ctl.clear) begin
            n_act = 1'b0;
        end else if (i_ctl.step) begin
            n_act = w_t | i_lstar_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_len == CNT_W'(IDX)) begin
            r_char <= i_ctl.chr;
        end
    end

endmodule

@@ rtl/wildcard_mask_match_core.sv @@
// Result: an end-of-name word's result is registered in the output or skid register.
// Throughput: one input word per cycle; each name character moves the active set
//   one step along the cell row, every cell updating at once from its left neighbor.
// Output: a result register plus one skid slot; input stalls only when both are full.
// Reset: synchronous, active low; clears mask lengths, flags, active bits and
//   output valids. Stored mask characters are not cleared.
module wildcard_mask_match_core #(
    parameter int MAX_MASK = wmm_pkg::MAX_MASK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wmm_in_if.sink      i_word,
    wmm_out_if.source   o_word
);

    localparam int CNT_W = $clog2(MAX_MASK + 1);

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_raw_len;    // characters appended, stars included
    logic [CNT_W-1:0] r_clen;       // characters stored, repeated stars dropped
    logic             r_ovf;
    logic             r_last_star;  // last stored character is '*'
    logic             r_start;      // next name character opens a new name
    logic [CNT_W-1:0] n_raw_len;
    logic [CNT_W-1:0] n_clen;
    logic             n_ovf;
    logic             n_last_star;
    logic             n_start;

    // output register and skid slot
    logic r_out_v;
    logic r_out_m;
    logic r_out_inv;
    logic r_skid_v;
    logic r_skid_m;
    logic r_skid_inv;
    logic n_out_v;
    logic n_skid_v;

    logic                       w_acc;
    wmm_pkg::t_op               w_op;
    logic [wmm_pkg::CHAR_W-1:0] w_chr;
    logic                       w_is_star;
    logic                       w_room;
    logic                       w_drop;
    logic                       w_res;
    logic                       w_inv;
    logic                       w_hit;
    logic                       w_pop;
    wmm_pkg::t_cell_ctl         w_ctl;

    // chain wires, one per position plus the tail position
    logic [MAX_MASK+1:0] w_fwd;
    logic [MAX_MASK+1:0] w_star_t;
    logic [MAX_MASK:0]   w_star_v;
    logic [MAX_MASK:0]   w_act;
    logic [MAX_MASK:0]   w_seed;

    assign i_word.ready = ~r_skid_v;
    assign w_acc        = i_word.valid & i_word.ready;
    assign w_op         = wmm_pkg::t_op'(i_word.operation);
    // folding is shared by store writes and name characters
    assign w_chr        = wmm_pkg::fold_upper(i_word.character);
    assign w_is_star    = w_chr == wmm_pkg::CH_STAR;
    assign w_room       = r_raw_len < CNT_W'(MAX_MASK);
    // "**" behaves as "*": keep only one so the empty-run step is a single hop
    assign w_drop       = w_is_star & r_last_star;

    assign w_ctl.wr    = w_acc & (w_op == wmm_pkg::OP_APPEND) & w_room & ~w_drop;
    assign w_ctl.step  = w_acc & (w_op == wmm_pkg::OP_NAME);
    assign w_ctl.clear = w_acc & (w_op == wmm_pkg::OP_CLEAR);
    assign w_ctl.start = r_start;
    assign w_ctl.chr   = w_chr;

    always_comb begin
        n_raw_len   = r_raw_len;
        n_clen      = r_clen;
        n_ovf       = r_ovf;
        n_last_star = r_last_star;
        n_start     = r_start;
        if (w_acc) begin
            unique case (w_op)
                wmm_pkg::OP_CLEAR: begin
                    n_raw_len   = '0;
                    n_clen      = '0;
                    n_ovf       = 1'b0;
                    n_last_star = 1'b0;
                    n_start     = 1'b1;
                end
                wmm_pkg::OP_APPEND: begin
                    if (w_room) begin
                        n_raw_len = r_raw_len + CNT_W'(1);
                        if (!w_drop) begin
                            n_clen      = r_clen + CNT_W'(1);
                            n_last_star = w_is_star;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_start = 1'b1;
                end
                wmm_pkg::OP_NAME: begin
                    n_start = 1'b0;
                end
                wmm_pkg::OP_END: begin
                    n_start = 1'b1;
                end
                default: begin
                    n_start = r_start;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // cell row: position i lives in cell i; the tail cell is never written
    // and only collects the final position
    // ---------------------------------------------------------------
    assign w_fwd[0]    = 1'b0;
    assign w_star_t[0] = 1'b0;

    always_comb begin
        w_seed    = '0;
        w_seed[0] = 1'b1;
        w_seed[1] = w_star_v[0];  // a leading star also opens position one
    end

    for (genvar g = 0; g <= MAX_MASK; g++) begin : g_cell
        wmm_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_len     (r_clen),
            .i_seed    (w_seed[g]),
            .i_fwd     (w_fwd[g]),
            .i_lstar_t (w_star_t[g]),
            .o_fwd     (w_fwd[g+1]),
            .o_star_t  (w_star_t[g+1]),
            .o_star_v  (w_star_v[g]),
            .o_act     (w_act[g])
        );
    end

    // whole name matched when the position just past the stored mask is live
    assign w_inv = (r_raw_len == '0) | r_ovf;
    assign w_hit = ~w_inv & w_act[r_clen];
    assign w_res = w_acc & (w_op == wmm_pkg::OP_END);

    // ---------------------------------------------------------------
    // result register with skid slot
    // ---------------------------------------------------------------
    assign w_pop = r_out_v & o_word.ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (!r_out_v || w_pop) begin
            n_out_v  = r_skid_v | w_res;
            n_skid_v = 1'b0;
        end else if (w_res) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_len   <= '0;
            r_clen      <= '0;
            r_ovf       <= 1'b0;
            r_last_star <= 1'b0;
            r_start     <= 1'b1;
            r_out_v     <= 1'b0;
            r_skid_v    <= 1'b0;
        end else begin
            r_raw_len   <= n_raw_len;
            r_clen      <= n_clen;
            r_ovf       <= n_ovf;
            r_last_star <= n_last_star;
            r_start     <= n_start;
            r_out_v     <= n_out_v;
            r_skid_v    <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_pop) begin
            if (r_skid_v) begin
                r_out_m   <= r_skid_m;
                r_out_inv <= r_skid_inv;
            end else begin
                r_out_m   <= w_hit;
                r_out_inv <= w_inv;
            end
        end else if (w_res) begin
            r_skid_m   <= w_hit;
            r_skid_inv <= w_inv;
        end
    end

    assign o_word.valid        = r_out_v;
    assign o_word.matched      = r_out_m;
    assign o_word.mask_invalid = r_out_inv;

`ifndef SYNTHESIS
    a_clen_le_raw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clen <= r_raw_len)
        else $error("stored length exceeds appended length");

    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot full while output register empty");

    a_ovf_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_raw_len == CNT_W'(MAX_MASK)))
        else $error("overflow flagged with room left");

    a_name_clears_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == wmm_pkg::OP_NAME) |=> !r_start)
        else $error("name character did not open the name");

    a_match_valid_mask : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_m) |-> !r_out_inv)
        else $error("match reported on invalid mask");
`endif

endmodule
